// ===== rtl/abp_pkg.sv =====
package abp_pkg;

  localparam int unsigned COUNT_WIDTH = 32;

  localparam logic [7:0] MAGIC_A = 8'h61;
  localparam logic [7:0] MAGIC_I = 8'h69;
  localparam logic [7:0] MAGIC_G = 8'h67;

  typedef enum logic [2:0] {
    KIND_HEADER = 3'd0,
    KIND_LATCH  = 3'd1,
    KIND_OUTPUT = 3'd2,
    KIND_AND    = 3'd3,
    KIND_END    = 3'd4,
    KIND_ERROR  = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE           = 3'd0,
    ERR_BAD_MAGIC      = 3'd1,
    ERR_BAD_NUMBER     = 3'd2,
    ERR_COUNT_MISMATCH = 3'd3,
    ERR_OVERLONG       = 3'd4,
    ERR_EARLY_END      = 3'd5
  } err_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] item_index;
    logic [31:0] value;
    logic [31:0] delta_first;
    logic [31:0] delta_second;
    err_e        error_code;
    logic        finished;
  } rec_t;

  function automatic logic [7:0] magic_char(input logic [1:0] pos);
    logic [7:0] c;
    case (pos)
      2'd0: c = MAGIC_A;
      2'd1: c = MAGIC_I;
      2'd2: c = MAGIC_G;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/abp_in_stage.sv =====
module abp_in_stage import abp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_i,
  input  logic advance_i,
  output logic held_valid_o,
  output in_t  held_o
);

  logic valid_q;
  in_t  data_q;
  logic accept;

  assign in_stall_o   = valid_q & ~advance_i;
  assign accept       = in_valid_i & ~in_stall_o;
  assign held_valid_o = valid_q;
  assign held_o       = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (advance_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= in_i;
    end
  end

endmodule

// ===== rtl/abp_parser.sv =====
module abp_parser import abp_pkg::*; #(
  parameter int unsigned CountWidth = COUNT_WIDTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic step_i,
  input  in_t  item_i,
  output logic rec_valid_o,
  output rec_t rec_o
);

  typedef enum logic [2:0] {
    PH_MAGIC,
    PH_HEADER,
    PH_LATCH,
    PH_OUTPUT,
    PH_AND,
    PH_COMPLETE
  } phase_e;

  typedef struct packed {
    phase_e                     phase;
    logic [1:0]                 mpos;
    logic [2:0]                 hidx;
    logic [4:0][CountWidth-1:0] counts;
    logic [31:0]                num;
    logic                       digit;
    logic [31:0]                vacc;
    logic [2:0]                 vcnt;
    logic [31:0]                held;
    logic                       pend;
    logic [31:0]                item;
    logic                       stopped;
  } st_t;

  function automatic logic [31:0] ext(input logic [CountWidth-1:0] c);
    return 32'(c);
  endfunction

  function automatic phase_e skip_empty(input phase_e p, input logic l_zero,
                                        input logic o_zero, input logic a_zero);
    phase_e r;
    r = p;
    if (r == PH_LATCH && l_zero) r = PH_OUTPUT;
    if (r == PH_OUTPUT && o_zero) r = PH_AND;
    if (r == PH_AND && a_zero) r = PH_COMPLETE;
    return r;
  endfunction

  st_t         state_q;
  st_t         state_d;
  st_t         cur;
  logic [7:0]  b;
  logic        is_ws;
  logic        is_dig;
  logic [35:0] num_ext;
  logic [35:0] nv;
  logic        over;
  logic        dec_err;
  logic        fin;
  logic [31:0] dec_v;
  logic [31:0] item_inc;
  logic [33:0] hdr_sum;
  logic [31:0] m_ext;
  logic        m_bad;
  logic [2:0]  vc_eff;
  logic [4:0]  vshift;
  logic [31:0] vacc_new;
  logic        verr;
  logic [31:0] lhs_sum;
  logic        have;
  err_e        err;
  rec_t        rec;

  assign cur      = item_i.first_byte ? st_t'('0) : state_q;
  assign b        = item_i.data_byte;
  assign is_ws    = (b == 8'h20) || (b >= 8'h09 && b <= 8'h0d);
  assign is_dig   = (b >= 8'h30) && (b <= 8'h39);
  assign num_ext  = {4'b0, cur.num};
  assign nv       = (num_ext << 3) + (num_ext << 1) + {32'b0, b[3:0]};
  assign over     = (cur.phase == PH_HEADER) ? ((nv >> CountWidth) != 36'd0)
                                             : (nv[35:32] != 4'd0);
  assign dec_err  = !is_ws && (!is_dig || over);
  assign fin      = (is_ws && cur.digit) || (is_dig && !over && item_i.last_byte);
  assign dec_v    = is_ws ? cur.num : nv[31:0];
  assign item_inc = cur.item + 32'd1;
  assign hdr_sum  = {2'b0, ext(cur.counts[1])} + {2'b0, ext(cur.counts[2])} + {2'b0, dec_v};
  assign m_ext    = ext(cur.counts[0]);
  assign m_bad    = m_ext[31] || ({2'b0, m_ext} != hdr_sum);
  assign vc_eff   = cur.vcnt[2] ? 3'd4 : cur.vcnt;
  assign vshift   = {2'b0, vc_eff} * 5'd7;
  assign vacc_new = cur.vacc | ({25'b0, b[6:0]} << vshift);
  assign verr     = cur.vcnt[2] && (b[7] || (b[6:4] != 3'd0));
  assign lhs_sum  = ext(cur.counts[1]) + ext(cur.counts[2]) + item_inc;

  always_comb begin
    state_d = cur;
    err     = ERR_NONE;
    have    = 1'b0;
    rec     = '0;
    if (!cur.stopped) begin
      case (cur.phase)
        PH_MAGIC: begin
          if (cur.mpos == 2'd3 || b != magic_char(cur.mpos)) begin
            err = ERR_BAD_MAGIC;
          end else begin
            state_d.mpos = cur.mpos + 2'd1;
            if (cur.mpos == 2'd2) state_d.phase = PH_HEADER;
          end
        end
        PH_HEADER, PH_LATCH, PH_OUTPUT: begin
          if (dec_err) begin
            err = ERR_BAD_NUMBER;
          end else begin
            if (is_dig) begin
              state_d.num   = nv[31:0];
              state_d.digit = 1'b1;
            end
            if (fin) begin
              state_d.num   = 32'd0;
              state_d.digit = 1'b0;
              case (cur.phase)
                PH_HEADER: begin
                  if (cur.hidx > 3'd4) begin
                    err = ERR_BAD_NUMBER;
                  end else begin
                    state_d.counts[cur.hidx] = dec_v[CountWidth-1:0];
                    state_d.hidx   = cur.hidx + 3'd1;
                    have           = 1'b1;
                    rec.kind       = KIND_HEADER;
                    rec.item_index = {29'b0, cur.hidx};
                    rec.value      = dec_v;
                    if (cur.hidx == 3'd4) begin
                      if (m_bad) begin
                        err = ERR_COUNT_MISMATCH;
                      end else begin
                        state_d.phase = skip_empty(PH_LATCH, cur.counts[2] == '0,
                                                   cur.counts[3] == '0, dec_v == 32'd0);
                        state_d.item  = 32'd0;
                        state_d.pend  = 1'b0;
                        state_d.vacc  = 32'd0;
                        state_d.vcnt  = 3'd0;
                      end
                    end
                  end
                end
                PH_LATCH: begin
                  have           = 1'b1;
                  rec.kind       = KIND_LATCH;
                  rec.item_index = cur.item;
                  rec.value      = dec_v;
                  state_d.item   = item_inc;
                  if (item_inc >= ext(cur.counts[2])) begin
                    state_d.phase = skip_empty(PH_OUTPUT, 1'b0, cur.counts[3] == '0,
                                               cur.counts[4] == '0);
                    state_d.item  = 32'd0;
                    state_d.pend  = 1'b0;
                    state_d.vacc  = 32'd0;
                    state_d.vcnt  = 3'd0;
                  end
                end
                default: begin
                  have           = 1'b1;
                  rec.kind       = KIND_OUTPUT;
                  rec.item_index = cur.item;
                  rec.value      = dec_v;
                  state_d.item   = item_inc;
                  if (item_inc >= ext(cur.counts[3])) begin
                    state_d.phase = skip_empty(PH_AND, 1'b0, 1'b0, cur.counts[4] == '0);
                    state_d.item  = 32'd0;
                    state_d.pend  = 1'b0;
                    state_d.vacc  = 32'd0;
                    state_d.vcnt  = 3'd0;
                  end
                end
              endcase
            end
          end
        end
        PH_AND: begin
          if (verr) begin
            err = ERR_OVERLONG;
          end else if (b[7]) begin
            state_d.vacc = vacc_new;
            state_d.vcnt = vc_eff + 3'd1;
          end else begin
            state_d.vacc = 32'd0;
            state_d.vcnt = 3'd0;
            if (!cur.pend) begin
              state_d.held = vacc_new;
              state_d.pend = 1'b1;
            end else begin
              have             = 1'b1;
              rec.kind         = KIND_AND;
              rec.item_index   = cur.item;
              rec.value        = {lhs_sum[30:0], 1'b0};
              rec.delta_first  = cur.held;
              rec.delta_second = vacc_new;
              state_d.pend     = 1'b0;
              state_d.item     = item_inc;
              if (item_inc >= ext(cur.counts[4])) state_d.phase = PH_COMPLETE;
            end
          end
        end
        default: begin
        end
      endcase
      if (err == ERR_NONE && item_i.last_byte) begin
        if (state_d.phase == PH_COMPLETE) begin
          state_d.stopped = 1'b1;
          if (!have) begin
            rec      = '0;
            rec.kind = KIND_END;
          end
          have         = 1'b1;
          rec.finished = 1'b1;
        end else begin
          err = ERR_EARLY_END;
        end
      end
      if (err != ERR_NONE) begin
        state_d.stopped = 1'b1;
        have            = 1'b1;
        rec             = '0;
        rec.kind        = KIND_ERROR;
        rec.error_code  = err;
      end
    end
  end

  assign rec_valid_o = have;
  assign rec_o       = rec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (step_i) begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/abp_out_stage.sv =====
module abp_out_stage import abp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  rec_t rec_i,
  output logic free_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rec_t rec_o
);

  logic valid_q;
  rec_t rec_q;

  assign free_o      = ~valid_q | ~out_stall_i;
  assign out_valid_o = valid_q;
  assign rec_o       = rec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rec_q <= rec_i;
    end
  end

endmodule

// ===== rtl/aiger_binary_stream_parser_top.sv =====
// Binary AIGER parser that takes the file one byte per word on the input
// channel, with first_byte marking the first byte and last_byte the final one.
// Each byte yields zero or one record on the output channel: a header count,
// a latch or output literal, an AND gate with its two deltas, an end record,
// or an error record; after an end or error record, bytes are ignored until
// first_byte restarts. A word is taken into an input register, decoded by
// the parser state logic while it is held there, and its record is loaded
// into an output register when the word advances, which it does once the
// output register is free. One byte is accepted every cycle as long as the
// receiver keeps taking records; the parser updates its state once for each
// byte that advances.
// While the receiver stalls, the record and the next byte stay in their
// registers, and in_stall_o rises only when both registers are occupied and
// the receiver stalls.
// Reset empties both registers and returns the parser to the magic check.
module aiger_binary_stream_parser_top import abp_pkg::*; #(
  parameter int unsigned CountWidth = COUNT_WIDTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        first_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  record_kind_o,
  output logic [31:0] item_index_o,
  output logic [31:0] value_o,
  output logic [31:0] delta_first_o,
  output logic [31:0] delta_second_o,
  output logic [2:0]  error_code_o,
  output logic        finished_o
);

  in_t  in_word;
  in_t  held;
  logic held_valid;
  logic free;
  logic step;
  logic rec_valid;
  rec_t rec;
  rec_t out_rec;

  assign in_word = '{data_byte: data_byte_i, first_byte: first_byte_i,
                     last_byte: last_byte_i};
  assign step    = held_valid & free;

  abp_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_i         (in_word),
    .advance_i    (step),
    .held_valid_o (held_valid),
    .held_o       (held)
  );

  abp_parser #(
    .CountWidth (CountWidth)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (held),
    .rec_valid_o (rec_valid),
    .rec_o       (rec)
  );

  abp_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step & rec_valid),
    .rec_i       (rec),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .rec_o       (out_rec)
  );

  assign record_kind_o  = out_rec.kind;
  assign item_index_o   = out_rec.item_index;
  assign value_o        = out_rec.value;
  assign delta_first_o  = out_rec.delta_first;
  assign delta_second_o = out_rec.delta_second;
  assign error_code_o   = out_rec.error_code;
  assign finished_o     = out_rec.finished;

endmodule
